// ===== rtl/core/sfhp_pkg.sv =====
`timescale 1ns / 1ps

package sfhp_pkg;

  // Frame store depth; position counter is fixed at 6 bits (depth up to 64)
  localparam int STORE_DEPTH = 32;
  localparam int POS_W       = 6;
  localparam int FIELD_LAST  = 10;

  localparam logic [7:0] HEADER_BYTE = 8'hAD;
  localparam logic [7:0] FRAME_LEN   = 8'h0C;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;

  // Raw characters of a closed frame; index 0 is the first character of a field
  typedef struct packed {
    logic [7:0]      mode_char;
    logic [3:0][7:0] freq_chars;
    logic [1:0][7:0] depth_chars;
    logic [1:0][7:0] dev_chars;
  } frame_chars_t;

  typedef struct packed {
    logic [7:0]  deviation_code;
    logic [7:0]  depth_code;
    logic [15:0] frequency_code;
    logic [7:0]  mode_code;
  } result_t;

endpackage

// ===== rtl/core/serial_frame_hex_field_parser.sv =====
`timescale 1ns / 1ps
// Output: the result is registered from the transaction carrying the frame's last byte.
// Throughput: one byte per cycle; field decode is a single pass from the held frame
// bytes into the output register. A spare register takes a result while the output
// is stalled, so input is held only while that spare register is full.
// Reset: synchronous, active-low rst_n closes any open frame, zeroes the position
// and empties both result registers.
module serial_frame_hex_field_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [7:0] mode_code, [23:8] frequency_code,
                                  // [31:24] depth_code, [39:32] deviation_code
);

  logic                   in_accept;
  logic                   out_free;
  logic                   frame_done;
  sfhp_pkg::frame_chars_t chars;
  sfhp_pkg::result_t      res;

  logic                   out_valid_r;
  sfhp_pkg::result_t      out_res_r;
  logic                   skid_valid_r;
  sfhp_pkg::result_t      skid_res_r;

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  sfhp_frame_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_accept),
    .byte_in    (in_tdata),
    .frame_done (frame_done),
    .chars      (chars)
  );

  sfhp_field_decode u_decode (
    .chars (chars),
    .res   (res)
  );

  // A full spare register blocks input, so it never fills in the same cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || frame_done;
      skid_valid_r <= 1'b0;
    end else if (frame_done) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
      end else if (frame_done) begin
        out_res_r <= res;
      end
    end
    if (!out_free && frame_done) begin
      skid_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

endmodule

// ===== rtl/core/sfhp_frame_track.sv =====
`timescale 1ns / 1ps

module sfhp_frame_track (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    byte_valid,
  input  logic [7:0]              byte_in,
  output logic                    frame_done,
  output sfhp_pkg::frame_chars_t  chars
);

  logic                         open_r, open_nxt;
  logic [sfhp_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]                   fld_r [sfhp_pkg::FIELD_LAST:1];

  logic [sfhp_pkg::POS_W:0]     pos_sum;
  logic [7:0]                   len_byte;
  logic                         is_header;

  assign pos_sum   = {1'b0, pos_r} + (sfhp_pkg::POS_W+1)'(1);
  assign is_header = (byte_in == sfhp_pkg::HEADER_BYTE);
  // length byte arrives at position 1; take it from the bus in that cycle
  assign len_byte  = (pos_r == sfhp_pkg::POS_W'(1)) ? byte_in : fld_r[1];

  always_comb begin
    open_nxt   = open_r;
    pos_nxt    = pos_r;
    frame_done = 1'b0;
    if (byte_valid) begin
      if (is_header) begin
        open_nxt = 1'b1;
        pos_nxt  = sfhp_pkg::POS_W'(1);
      end else if (open_r) begin
        if (pos_sum >= (sfhp_pkg::POS_W+1)'(sfhp_pkg::STORE_DEPTH)) begin
          // store depth reached: drop the frame
          open_nxt = 1'b0;
          pos_nxt  = '0;
        end else if (8'(pos_sum[sfhp_pkg::POS_W-1:0]) == len_byte) begin
          open_nxt   = 1'b0;
          pos_nxt    = '0;
          frame_done = (len_byte == sfhp_pkg::FRAME_LEN);
        end else begin
          pos_nxt = pos_sum[sfhp_pkg::POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      open_r <= open_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // Hold only the length byte and the bytes that the result needs
  always_ff @(posedge clk) begin
    if (byte_valid && open_r && !is_header) begin
      for (int k = 1; k <= sfhp_pkg::FIELD_LAST; k++) begin
        if (pos_r == sfhp_pkg::POS_W'(k)) begin
          fld_r[k] <= byte_in;
        end
      end
    end
  end

  assign chars.mode_char      = fld_r[2];
  assign chars.freq_chars[0]  = fld_r[3];
  assign chars.freq_chars[1]  = fld_r[4];
  assign chars.freq_chars[2]  = fld_r[5];
  assign chars.freq_chars[3]  = fld_r[6];
  assign chars.depth_chars[0] = fld_r[7];
  assign chars.depth_chars[1] = fld_r[8];
  assign chars.dev_chars[0]   = fld_r[9];
  assign chars.dev_chars[1]   = fld_r[10];

endmodule

// ===== rtl/core/sfhp_field_decode.sv =====
`timescale 1ns / 1ps

module sfhp_field_decode (
  input  sfhp_pkg::frame_chars_t chars,
  output sfhp_pkg::result_t      res
);

  // bit 4 flags a hex character, bits 3:0 carry its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      d = {1'b1, c[3:0] + 4'd9};
    end else begin
      d = '0;
    end
    return d;
  endfunction

  function automatic logic [15:0] hex4(input logic [3:0][7:0] c);
    logic [15:0] acc;
    logic        run;
    logic [4:0]  d;
    acc = '0;
    run = 1'b1;
    for (int k = 0; k < 4; k++) begin
      d = hex_digit(c[k]);
      if (run && d[4]) begin
        acc = {acc[11:0], d[3:0]};
      end else begin
        run = 1'b0;
      end
    end
    return acc;
  endfunction

  function automatic logic [7:0] hex2(input logic [1:0][7:0] c);
    logic [7:0] acc;
    logic       run;
    logic [4:0] d;
    acc = '0;
    run = 1'b1;
    for (int k = 0; k < 2; k++) begin
      d = hex_digit(c[k]);
      if (run && d[4]) begin
        acc = {acc[3:0], d[3:0]};
      end else begin
        run = 1'b0;
      end
    end
    return acc;
  endfunction

  assign res.mode_code      = chars.mode_char - sfhp_pkg::ASCII_ZERO;
  assign res.frequency_code = hex4(chars.freq_chars);
  assign res.depth_code     = hex2(chars.depth_chars);
  assign res.deviation_code = hex2(chars.dev_chars);

endmodule
